// ===== rtl/core/tmsq_pkg.sv =====
// Shared constants, codes and types for the two-wire master sequencer.
package tmsq_pkg;

	localparam int BUF_DEPTH = 16;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int PTR_W     = $clog2(BUF_DEPTH + 1);

	// host / bus modes
	localparam logic [2:0] MODE_LOAD     = 3'd0;
	localparam logic [2:0] MODE_START_WR = 3'd1;
	localparam logic [2:0] MODE_START_RD = 3'd2;
	localparam logic [2:0] MODE_REPEAT   = 3'd3;
	localparam logic [2:0] MODE_BUS      = 3'd4;
	localparam logic [2:0] MODE_READ     = 3'd5;

	// bus status codes
	localparam logic [3:0] ST_START       = 4'd0;
	localparam logic [3:0] ST_REP_START   = 4'd1;
	localparam logic [3:0] ST_MT_ADR_ACK  = 4'd2;
	localparam logic [3:0] ST_MT_DATA_ACK = 4'd3;
	localparam logic [3:0] ST_MR_DATA_ACK = 4'd4;
	localparam logic [3:0] ST_MR_ADR_ACK  = 4'd5;
	localparam logic [3:0] ST_MR_DATA_NACK = 4'd6;
	localparam logic [3:0] ST_ARB_LOST    = 4'd7;
	localparam logic [3:0] ST_MT_ADR_NACK = 4'd8;
	localparam logic [3:0] ST_MR_ADR_NACK = 4'd9;
	localparam logic [3:0] ST_MT_DATA_NACK = 4'd10;
	localparam logic [3:0] ST_BUS_ERROR   = 4'd11;

	// fault codes
	localparam logic [2:0] FAULT_NONE  = 3'd0;
	localparam logic [2:0] FAULT_OTHER = 3'd5;

	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] slave_addr;
		logic [3:0] byte_count;
		logic [3:0] buffer_index;
		logic [7:0] msg_byte;
		logic [3:0] bus_status;
		logic [7:0] bus_data;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic       busy_res;
		logic       go;
		logic       send_start;
		logic       send_stop;
		logic       send_ack;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last_ok;
		logic [2:0] fault_code;
		logic [7:0] read_byte;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [BUF_AW-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

endpackage

// ===== rtl/core/tmsq_buf.sv =====
// Message buffer: one write port, two registered read ports, per-entry valid bits.
module tmsq_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tmsq_pkg::buf_wr_t         wr,
	input  logic                      rd_en,
	input  logic [tmsq_pkg::BUF_AW-1:0] rd_addr_a,
	input  logic [tmsq_pkg::BUF_AW-1:0] rd_addr_b,
	output logic [7:0]                rd_data_a,
	output logic [7:0]                rd_data_b
);

	logic [7:0]                    mem [tmsq_pkg::BUF_DEPTH];
	logic [tmsq_pkg::BUF_DEPTH-1:0] valid_q;

	logic [7:0] raw_a_s1, raw_b_s1, fwd_data_s1;
	logic       vld_a_s1, vld_b_s1, fwd_a_s1, fwd_b_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// a write landing in the same cycle is forwarded past the array
	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_a_s1    <= mem[rd_addr_a];
			raw_b_s1    <= mem[rd_addr_b];
			vld_a_s1    <= valid_q[rd_addr_a];
			vld_b_s1    <= valid_q[rd_addr_b];
			fwd_a_s1    <= wr.en && (wr.addr == rd_addr_a);
			fwd_b_s1    <= wr.en && (wr.addr == rd_addr_b);
			fwd_data_s1 <= wr.data;
		end
	end

	assign rd_data_a = fwd_a_s1 ? fwd_data_s1 : (vld_a_s1 ? raw_a_s1 : 8'd0);
	assign rd_data_b = fwd_b_s1 ? fwd_data_s1 : (vld_b_s1 ? raw_b_s1 : 8'd0);

endmodule

// ===== rtl/core/tmsq_ctl.sv =====
// Transfer control: state registers and the per-transaction decode.
module tmsq_ctl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       proc,
	input  tmsq_pkg::item_t            item,
	input  logic [7:0]                 rd_data_a,
	input  logic [7:0]                 rd_data_b,
	output logic [tmsq_pkg::PTR_W-1:0] ptr_next,
	output tmsq_pkg::buf_wr_t          wr,
	output tmsq_pkg::result_t          res
);

	logic [tmsq_pkg::PTR_W-1:0] len_q, len_d;
	logic [tmsq_pkg::PTR_W-1:0] ptr_q, ptr_d, ptr_base, ptr_bump;
	logic                       busy_q, busy_d, ok_q, ok_d;
	logic [2:0]                 fault_q, fault_d;
	logic [4:0]                 idx_p1, cnt_p1;
	logic [tmsq_pkg::PTR_W:0]   ptr_d_p1;
	tmsq_pkg::buf_wr_t          wr_c;
	logic                       begin_xfer;

	always_comb begin
		res        = '0;
		wr_c       = '0;
		len_d      = len_q;
		ptr_d      = ptr_q;
		busy_d     = busy_q;
		ok_d       = ok_q;
		fault_d    = fault_q;
		begin_xfer = 1'b0;
		idx_p1     = {1'b0, item.buffer_index} + 5'd1;
		cnt_p1     = {1'b0, item.byte_count} + 5'd1;
		ptr_base   = (item.bus_status <= tmsq_pkg::ST_REP_START) ? '0 : ptr_q;
		ptr_bump   = (32'(ptr_base) < tmsq_pkg::BUF_DEPTH) ?
			ptr_base + tmsq_pkg::PTR_W'(1) : ptr_base;
		ptr_d_p1   = '0;

		unique case (item.mode)
			tmsq_pkg::MODE_LOAD, tmsq_pkg::MODE_START_WR, tmsq_pkg::MODE_START_RD,
			tmsq_pkg::MODE_REPEAT, tmsq_pkg::MODE_READ: begin
				if (!busy_q) begin
					res.accepted = 1'b1;
					unique case (item.mode)
						tmsq_pkg::MODE_LOAD: begin
							if (32'(idx_p1) < tmsq_pkg::BUF_DEPTH) begin
								wr_c.en   = 1'b1;
								wr_c.addr = tmsq_pkg::BUF_AW'(idx_p1);
								wr_c.data = item.msg_byte;
							end
						end
						tmsq_pkg::MODE_START_WR, tmsq_pkg::MODE_START_RD: begin
							len_d = (32'(cnt_p1) > tmsq_pkg::BUF_DEPTH) ?
								tmsq_pkg::PTR_W'(tmsq_pkg::BUF_DEPTH) :
								tmsq_pkg::PTR_W'(cnt_p1);
							wr_c.en   = 1'b1;
							wr_c.addr = '0;
							wr_c.data = {item.slave_addr,
								item.mode == tmsq_pkg::MODE_START_RD};
							begin_xfer = 1'b1;
						end
						tmsq_pkg::MODE_REPEAT: begin
							begin_xfer = 1'b1;
						end
						default: begin
							if (ok_q && 32'(item.buffer_index) < tmsq_pkg::BUF_DEPTH)
								res.read_byte = rd_data_b;
						end
					endcase
				end
			end
			tmsq_pkg::MODE_BUS: begin
				if (busy_q) begin
					res.accepted = 1'b1;
					case (item.bus_status) inside
						tmsq_pkg::ST_START, tmsq_pkg::ST_REP_START,
						tmsq_pkg::ST_MT_ADR_ACK, tmsq_pkg::ST_MT_DATA_ACK: begin
							res.go = 1'b1;
							if (ptr_base < len_q) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = rd_data_a;
								ptr_d        = ptr_bump;
							end else begin
								ptr_d         = ptr_base;
								ok_d          = 1'b1;
								busy_d        = 1'b0;
								res.send_stop = 1'b1;
							end
						end
						tmsq_pkg::ST_MR_DATA_ACK, tmsq_pkg::ST_MR_ADR_ACK: begin
							if (item.bus_status == tmsq_pkg::ST_MR_DATA_ACK) begin
								if (32'(ptr_q) < tmsq_pkg::BUF_DEPTH) begin
									wr_c.en   = 1'b1;
									wr_c.addr = tmsq_pkg::BUF_AW'(ptr_q);
									wr_c.data = item.bus_data;
								end
								ptr_d = ptr_bump;
							end
							ptr_d_p1     = {1'b0, ptr_d} + (tmsq_pkg::PTR_W + 1)'(1);
							res.go       = 1'b1;
							res.send_ack = ptr_d_p1 < {1'b0, len_q};
						end
						tmsq_pkg::ST_MR_DATA_NACK: begin
							if (32'(ptr_q) < tmsq_pkg::BUF_DEPTH) begin
								wr_c.en   = 1'b1;
								wr_c.addr = tmsq_pkg::BUF_AW'(ptr_q);
								wr_c.data = item.bus_data;
							end
							ok_d          = 1'b1;
							busy_d        = 1'b0;
							res.go        = 1'b1;
							res.send_stop = 1'b1;
						end
						tmsq_pkg::ST_ARB_LOST: begin
							res.go         = 1'b1;
							res.send_start = 1'b1;
						end
						tmsq_pkg::ST_MT_ADR_NACK, tmsq_pkg::ST_MR_ADR_NACK,
						tmsq_pkg::ST_MT_DATA_NACK, tmsq_pkg::ST_BUS_ERROR: begin
							fault_d = 3'(item.bus_status - tmsq_pkg::ST_ARB_LOST);
							busy_d  = 1'b0;
						end
						default: begin
							fault_d = tmsq_pkg::FAULT_OTHER;
							busy_d  = 1'b0;
						end
					endcase
				end
			end
			default: ;
		endcase

		if (begin_xfer) begin
			ok_d           = 1'b0;
			fault_d        = tmsq_pkg::FAULT_NONE;
			busy_d         = 1'b1;
			res.go         = 1'b1;
			res.send_start = 1'b1;
		end

		res.busy_res   = busy_d;
		res.last_ok    = ok_d;
		res.fault_code = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ptr_q   <= '0;
			busy_q  <= 1'b0;
			ok_q    <= 1'b0;
			fault_q <= tmsq_pkg::FAULT_NONE;
		end else if (proc) begin
			len_q   <= len_d;
			ptr_q   <= ptr_d;
			busy_q  <= busy_d;
			ok_q    <= ok_d;
			fault_q <= fault_d;
		end
	end

	assign ptr_next = proc ? ptr_d : ptr_q;

	always_comb begin
		wr    = wr_c;
		wr.en = wr_c.en && proc;
	end

endmodule

// ===== rtl/core/two_wire_master_sequencer_core.sv =====
// Top level of the two-wire master transfer sequencer.
//
// Usage: one input channel (in_valid / in_stall) carries host commands
// (load byte, start write, start read, repeat, read byte) and bus status
// events from the bit engine. Every accepted transaction yields exactly one
// result transaction on the output channel (out_valid / out_stall) holding
// the bus command (go, start, stop, ack, byte to send), busy/ok/fault
// status and, for read byte, the buffer contents.
// An accepted item is held in the input register, then decoded into the
// result register.
// Throughput: one transaction per cycle while the receiver does not stall;
// the decode and the buffer write-back of one item happen in the same
// cycle, and the buffer read for the next item is issued with its
// acceptance, forwarding any write that lands in the same cycle.
// Reset (arst_n low) empties both pipeline stages, clears busy, ok, fault,
// length and pointer, and marks every buffer entry as zero at once.
// When the receiver stalls, the result register holds, the item in the
// input register waits, and in_stall rises once that register is full.
module two_wire_master_sequencer_core (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] mode,
	input  logic [6:0] slave_addr,
	input  logic [3:0] byte_count,
	input  logic [3:0] buffer_index,
	input  logic [7:0] msg_byte,
	input  logic [3:0] bus_status,
	input  logic [7:0] bus_data,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic       busy_res,
	output logic       go,
	output logic       send_start,
	output logic       send_stop,
	output logic       send_ack,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       last_ok,
	output logic [2:0] fault_code,
	output logic [7:0] read_byte
);

	tmsq_pkg::item_t            item_s1;
	logic                       valid_s1;
	tmsq_pkg::result_t          res_c, res_q;
	logic                       out_valid_q;
	logic                       proc, in_acc;
	logic [tmsq_pkg::PTR_W-1:0] ptr_next;
	logic [tmsq_pkg::BUF_AW-1:0] rd_addr_a;
	logic [7:0]                 rd_data_a, rd_data_b;
	tmsq_pkg::buf_wr_t          wr;

	// stage 1 advances whenever the result register is free or draining
	assign proc     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !proc;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc || proc) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= '{mode: mode, slave_addr: slave_addr, byte_count: byte_count,
				buffer_index: buffer_index, msg_byte: msg_byte,
				bus_status: bus_status, bus_data: bus_data};
		end
	end

	// tx read: start / repeated start rewinds the pointer to the address byte
	assign rd_addr_a = (mode == tmsq_pkg::MODE_BUS && bus_status <= tmsq_pkg::ST_REP_START) ?
		'0 : tmsq_pkg::BUF_AW'(ptr_next);

	tmsq_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_en    (in_acc),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(tmsq_pkg::BUF_AW'(buffer_index)),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	tmsq_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.proc     (proc),
		.item     (item_s1),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.ptr_next (ptr_next),
		.wr       (wr),
		.res      (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = res_q.accepted;
	assign busy_res   = res_q.busy_res;
	assign go         = res_q.go;
	assign send_start = res_q.send_start;
	assign send_stop  = res_q.send_stop;
	assign send_ack   = res_q.send_ack;
	assign tx_valid   = res_q.tx_valid;
	assign tx_byte    = res_q.tx_byte;
	assign last_ok    = res_q.last_ok;
	assign fault_code = res_q.fault_code;
	assign read_byte  = res_q.read_byte;

endmodule
